[rtl/usart_status_irq_regs_assert.svh]
// Assertion macros shared by the USART status/IRQ register block.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef USART_STATUS_IRQ_REGS_ASSERT_SVH
`define USART_STATUS_IRQ_REGS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define USIR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usir assertion failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define USIR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usir assertion failed (next cycle)");

`endif

[rtl/usir_pkg.sv]
// ============================================================================
// usir_pkg
// Types and constants of the USART status and interrupt register block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package usir_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RX    = 2'd2
    } cmd_t;

    // Register byte offsets
    localparam logic [4:0] OFF_SR   = 5'h00;
    localparam logic [4:0] OFF_DR   = 5'h04;
    localparam logic [4:0] OFF_BRR  = 5'h08;
    localparam logic [4:0] OFF_CR1  = 5'h0c;
    localparam logic [4:0] OFF_CR2  = 5'h10;
    localparam logic [4:0] OFF_CR3  = 5'h14;
    localparam logic [4:0] OFF_GTPR = 5'h18;

    // Writable bits of the control registers
    localparam logic [13:0] CR1_MASK = 14'h3FFF;
    localparam logic [14:0] CR2_MASK = 15'h7F7F;
    localparam logic [10:0] CR3_MASK = 11'h07FF;

    // CR1 bit positions
    localparam int unsigned CR1_UE     = 13;
    localparam int unsigned CR1_TXEIE  = 7;
    localparam int unsigned CR1_TCIE   = 6;
    localparam int unsigned CR1_RXNEIE = 5;
    localparam int unsigned CR1_TE     = 3;
    localparam int unsigned CR1_RE     = 2;

    // SR bit positions
    localparam int unsigned SR_TXE  = 7;
    localparam int unsigned SR_TC   = 6;
    localparam int unsigned SR_RXNE = 5;
    localparam int unsigned SR_ORE  = 3;

    // Transmit data register is always empty in this model
    localparam logic TXE_FLAG = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  reg_offset;
        logic [15:0] write_value;
        logic [7:0]  rx_byte;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_level;
        logic        tx_valid;
        logic [7:0]  tx_byte;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/usir_if.sv]
// ============================================================================
// usir_if
// Valid/ready channel interfaces for requests and responses.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface usir_req_if;
    import usir_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface usir_rsp_if;
    import usir_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/usir_in_reg.sv]
// ============================================================================
// usir_in_reg
// Input register stage: captures one request transaction per cycle while it has room.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module usir_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire usir_pkg::req_t req_data,
    output logic               req_ready,
    input  wire logic          advance,
    output logic               item_valid,
    output usir_pkg::req_t     item
);
    import usir_pkg::*;

    logic valid_reg;
    req_t item_reg;

    // Room when empty or when the held transaction moves on this cycle
    assign req_ready  = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            item_reg <= req_data;
        end
    end

endmodule

`default_nettype wire

[rtl/usir_core.sv]
// ============================================================================
// usir_core
// Register file, status flags, interrupt logic and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "usart_status_irq_regs_assert.svh"

module usir_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire usir_pkg::req_t item,
    output logic                advance,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output usir_pkg::rsp_t      rsp_data
);
    import usir_pkg::*;

    logic        rxne_reg, rxne_next;
    logic        ore_reg, ore_next;
    logic        tc_reg, tc_next;
    logic        armed_reg, armed_next;
    logic [2:0]  irq_en_reg, irq_en_next;
    logic [7:0]  rx_data_reg, rx_data_next;
    logic [13:0] cr1_reg, cr1_next;
    logic [14:0] cr2_reg, cr2_next;
    logic [10:0] cr3_reg, cr3_next;
    logic [15:0] brr_reg, brr_next;
    logic [15:0] gtpr_reg, gtpr_next;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg, rsp_next;
    logic        unit_on;
    logic [15:0] status_word;

    assign advance   = item_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign unit_on = cr1_reg[CR1_UE];

    always_comb
    begin
        status_word          = '0;
        status_word[SR_TXE]  = TXE_FLAG;
        status_word[SR_TC]   = tc_reg;
        status_word[SR_RXNE] = rxne_reg;
        status_word[SR_ORE]  = ore_reg;
    end

    always_comb
    begin
        rxne_next    = rxne_reg;
        ore_next     = ore_reg;
        tc_next      = tc_reg;
        armed_next   = armed_reg;
        irq_en_next  = irq_en_reg;
        rx_data_next = rx_data_reg;
        cr1_next     = cr1_reg;
        cr2_next     = cr2_reg;
        cr3_next     = cr3_reg;
        brr_next     = brr_reg;
        gtpr_next    = gtpr_reg;
        rsp_next     = '0;

        unique case (cmd_t'(item.command))
            CMD_WRITE:
            begin
                unique case (item.reg_offset)
                    OFF_SR:
                    begin
                        // Write zero to clear
                        if (!item.write_value[SR_RXNE])
                        begin
                            rxne_next = 1'b0;
                        end
                        if (!item.write_value[SR_TC])
                        begin
                            tc_next = 1'b0;
                        end
                    end
                    OFF_DR:
                    begin
                        if (unit_on && cr1_reg[CR1_TE])
                        begin
                            rsp_next.tx_valid = 1'b1;
                            rsp_next.tx_byte  = item.write_value[7:0];
                        end
                    end
                    OFF_BRR:
                    begin
                        brr_next = item.write_value;
                    end
                    OFF_CR1:
                    begin
                        cr1_next    = item.write_value[13:0] & CR1_MASK;
                        irq_en_next = {item.write_value[CR1_TXEIE],
                                       item.write_value[CR1_TCIE],
                                       item.write_value[CR1_RXNEIE]};
                    end
                    OFF_CR2:
                    begin
                        cr2_next = item.write_value[14:0] & CR2_MASK;
                    end
                    OFF_CR3:
                    begin
                        cr3_next = item.write_value[10:0] & CR3_MASK;
                    end
                    OFF_GTPR:
                    begin
                        gtpr_next = item.write_value;
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_READ:
            begin
                unique case (item.reg_offset)
                    OFF_SR:
                    begin
                        // Arm overrun clear; a following DR read completes it
                        armed_next         = ore_reg;
                        rsp_next.read_data = status_word;
                    end
                    OFF_DR:
                    begin
                        if (armed_reg)
                        begin
                            armed_next = 1'b0;
                            ore_next   = 1'b0;
                        end
                        rxne_next          = 1'b0;
                        rsp_next.read_data = {8'h00, rx_data_reg};
                    end
                    OFF_BRR:  rsp_next.read_data = brr_reg;
                    OFF_CR1:  rsp_next.read_data = {2'b00, cr1_reg};
                    OFF_CR2:  rsp_next.read_data = {1'b0, cr2_reg};
                    OFF_CR3:  rsp_next.read_data = {5'b00000, cr3_reg};
                    OFF_GTPR: rsp_next.read_data = gtpr_reg;
                    default:  rsp_next.read_data = '0;
                endcase
            end
            CMD_RX:
            begin
                if (unit_on && cr1_reg[CR1_RE])
                begin
                    rx_data_next = item.rx_byte;
                    if (rxne_reg)
                    begin
                        ore_next   = 1'b1;
                        armed_next = 1'b0;
                    end
                    else
                    begin
                        rxne_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Overrun shares the receive interrupt enable
        rsp_next.irq_level = (irq_en_next[0] && (rxne_next || ore_next))
                           || (irq_en_next[1] && tc_next)
                           || (irq_en_next[2] && TXE_FLAG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rxne_reg    <= 1'b0;
            ore_reg     <= 1'b0;
            tc_reg      <= 1'b1;
            armed_reg   <= 1'b0;
            irq_en_reg  <= '0;
            rx_data_reg <= '0;
            cr1_reg     <= '0;
            cr2_reg     <= '0;
            cr3_reg     <= '0;
            brr_reg     <= '0;
            gtpr_reg    <= '0;
        end
        else if (advance)
        begin
            rxne_reg    <= rxne_next;
            ore_reg     <= ore_next;
            tc_reg      <= tc_next;
            armed_reg   <= armed_next;
            irq_en_reg  <= irq_en_next;
            rx_data_reg <= rx_data_next;
            cr1_reg     <= cr1_next;
            cr2_reg     <= cr2_next;
            cr3_reg     <= cr3_next;
            brr_reg     <= brr_next;
            gtpr_reg    <= gtpr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || rsp_ready)
        begin
            rsp_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `USIR_ASSERT_NXT(a_overrun_sets, advance && (item.command == CMD_RX) && unit_on && cr1_reg[CR1_RE] && rxne_reg, ore_reg && !armed_reg)
    `USIR_ASSERT_NXT(a_dr_read_clears_rxne, advance && (item.command == CMD_READ) && (item.reg_offset == OFF_DR), !rxne_reg)
    `USIR_ASSERT_NXT(a_regs_hold_when_idle, !advance, $stable(cr1_reg) && $stable(irq_en_reg) && $stable(rxne_reg))
    `USIR_ASSERT_IMP(a_tx_byte_zero, rsp_valid_reg && !rsp_reg.tx_valid, rsp_reg.tx_byte == 8'h00)

endmodule

`default_nettype wire

[rtl/usart_status_irq_regs.sv]
// ============================================================================
// usart_status_irq_regs
// USART status flags, control registers and interrupt line.
// ============================================================================
// Usage:
//   req carries one transaction per item: a bus write, a bus read or a byte
//   from the serial receiver, chosen by command. rsp returns one transaction
//   per item with read data, the interrupt level after the item and any
//   byte handed to the transmitter.
//   Throughput is one item per cycle while rsp is not stalled: the whole
//   update is a single pass of flag and decode logic between the input
//   register and the result register.
//   An accepted item sits in the input register, then loads the result
//   register, from which rsp presents it to the receiver.
//   Reset clears the control registers and flags; TC and TXE come up set,
//   no transaction is held in either stage.
//   When the receiver stalls rsp, the result register holds its
//   transaction and the input register, if empty, still takes one more item;
//   after that req.ready drops until rsp drains.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module usart_status_irq_regs (
    input  wire logic   clk,
    input  wire logic   rst_n,
    usir_req_if.sink    req,
    usir_rsp_if.source  rsp
);
    import usir_pkg::*;

    logic advance;
    logic item_valid;
    req_t item;

    usir_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_data   (req.data),
        .req_ready  (req.ready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    usir_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_data   (rsp.data)
    );

endmodule

`default_nettype wire
